// File: rtl/core/hrc_pkg.sv
// hrc_pkg: shared types, constants and helpers of the transform composer
// depends on nothing; imported by hierarchy_transform_compose and hrc_mac
package hrc_pkg;

    localparam int NODES_DEF = 256;
    localparam int FRAC_DEF  = 16;
    localparam int CNT_W     = 9;

    localparam logic [15:0] NO_PARENT = 16'hFFFF;

    localparam logic [3:0] SEL_POS0   = 4'd9;
    localparam logic [3:0] SEL_PARENT = 4'd12;
    localparam logic [3:0] ELEM_LAST  = 4'd11;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ENDPOINT  = 3'd1;
    localparam logic [2:0] ST_PARENT    = 3'd2;
    localparam logic [2:0] ST_CYCLE     = 3'd3;
    localparam logic [2:0] ST_ROOTS     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    typedef struct packed {
        logic               action;
        logic [15:0]        node_index;
        logic [15:0]        owner_index;
        logic [3:0]         word_select;
        logic signed [31:0] word_value;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         element;
        logic signed [31:0] result_value;
        logic [2:0]         status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
    } mac_ctl_t;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
    } sat_t;

    // saturating 32-bit add or subtract
    function automatic sat_t sat_addsub(logic [31:0] a, logic [31:0] b, logic sub);
        logic signed [32:0] s;
        sat_t r;
        s = sub ? (33'(signed'(a)) - 33'(signed'(b))) : (33'(signed'(a)) + 33'(signed'(b)));
        r.ovf = (s[32] != s[31]);
        if (!r.ovf)
        begin
            r.value = s[31:0];
        end
        else if (s[32])
        begin
            r.value = 32'h8000_0000;
        end
        else
        begin
            r.value = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // matrix entry used for output o, term t
    function automatic logic [3:0] mat_index(logic inv, logic [1:0] o, logic [1:0] t);
        logic [3:0] r;
        if (inv)
        begin
            r = 4'((2 - o) * 3 + t);
        end
        else
        begin
            r = 4'(6 - 3 * t + o);
        end
        return r;
    endfunction

    // start basis has a one on the anti-diagonal
    function automatic logic start_unit(int i);
        return (i == 2) || (i == 4) || (i == 6);
    endfunction

endpackage

// File: rtl/core/hierarchy_transform_compose.sv
// hierarchy_transform_compose: node stores, chain walker and composition sequencer
// depends on hrc_pkg, hrc_ram, hrc_mac
//
//  channel   | handshake          | payload
//  command   | start / busy       | cmd (cmd_t)
//  result    | strobe             | result (res_t)
//  config    | cfg_we             | cfg_wdata (node_count)
//
// a write transaction is taken only while idle; busy stays low
// a query walks the picture chain and then the owner chain, reading one parent per node,
// then for each picture node and each owner node below the shared root loads nine matrix
// and three offset words, runs 36 multiply-adds on the one multiplier, rounds each output,
// writes back each vector and applies the offset (added for picture nodes, subtracted for
// owner nodes), then sends 12 results or one error result
// reset clears control only; node stores are undefined until written
// results leave one per cycle with no back-pressure
module hierarchy_transform_compose #(
    parameter int MAX_NODES = hrc_pkg::NODES_DEF,
    parameter int FRAC_BITS = hrc_pkg::FRAC_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  hrc_pkg::cmd_t                cmd,
    input  logic                         cfg_we,
    input  logic [hrc_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                         strobe,
    output hrc_pkg::res_t                result
);
    import hrc_pkg::*;

    localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int MD   = MAX_NODES * 9;
    localparam int OD   = MAX_NODES * 3;
    localparam int MAW  = $clog2(MD);
    localparam int OAW  = $clog2(OD);

    typedef enum logic [4:0] {
        S_IDLE, S_PW, S_PW_RD, S_OW, S_OW_RD, S_INIT, S_LD, S_SUB, S_MUL, S_ACC,
        S_RND, S_CMT, S_ADD, S_NEXT, S_LST, S_FIN, S_EMIT, S_ERR
    } state_t;

    state_t        state_reg, state_next;
    logic [CNT_W-1:0] node_count_reg;
    logic [CW-1:0] count;
    logic [15:0]   cur_reg, cur_next;
    logic [15:0]   own_reg, own_next;
    logic [15:0]   pic_reg, pic_next;
    logic [15:0]   last_reg, last_next;
    logic [15:0]   root_reg, root_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] olen_reg, olen_next;
    logic [CW-1:0] k_reg, k_next;
    logic [NW-1:0] node_reg, node_next;
    logic [3:0]    ld_reg, ld_next;
    logic [1:0]    vi_reg, vi_next;
    logic [1:0]    oi_reg, oi_next;
    logic [1:0]    ti_reg, ti_next;
    logic          inv_reg, inv_next;
    logic          ovf_reg, ovf_next;
    logic [2:0]    status_reg, status_next;
    logic [3:0]    elem_reg, elem_next;
    logic [31:0]   work_reg [12];
    logic [31:0]   work_next [12];
    logic [31:0]   mat_reg [9];
    logic [31:0]   mat_next [9];
    logic [31:0]   off_reg [3];
    logic [31:0]   off_next [3];
    logic [31:0]   tmp_reg [3];
    logic [31:0]   tmp_next [3];
    logic          strobe_next;
    res_t          result_reg, result_next;

    logic          accept_wr;
    logic          node_ok;
    logic          m_we, o_we, p_we, l_we;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [OAW-1:0] o_waddr, o_raddr;
    logic [31:0]   m_rdata, o_rdata;
    logic [NW-1:0] p_raddr;
    logic [15:0]   p_rdata;
    logic [NW-1:0] l_raddr;
    logic [NW-1:0] l_rdata;
    logic [3:0]    wsel;
    logic [3:0]    ld_m1;
    mac_ctl_t      mctl;
    sat_t          rnd;
    sat_t          s0, s1, s2;

    assign count = (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign busy  = (state_reg != S_IDLE);

    // write transactions
    assign accept_wr = start && !busy && (cmd.action == ACT_WRITE);
    assign node_ok   = (32'(cmd.node_index) < MAX_NODES);
    assign m_we      = accept_wr && node_ok && (cmd.word_select < SEL_POS0);
    assign o_we      = accept_wr && node_ok && (cmd.word_select >= SEL_POS0)
                       && (cmd.word_select < SEL_PARENT);
    assign p_we      = accept_wr && node_ok && (cmd.word_select == SEL_PARENT);
    assign m_waddr   = (MAW'(cmd.node_index[NW-1:0]) << 3) + MAW'(cmd.node_index[NW-1:0])
                       + MAW'(cmd.word_select);
    assign o_waddr   = (OAW'(cmd.node_index[NW-1:0]) << 1) + OAW'(cmd.node_index[NW-1:0])
                       + OAW'(cmd.word_select - SEL_POS0);

    // node load reads
    assign m_raddr = (MAW'(node_reg) << 3) + MAW'(node_reg) + MAW'((ld_reg < 4'd9) ? ld_reg : 4'd0);
    assign o_raddr = (OAW'(node_reg) << 1) + OAW'(node_reg) + OAW'((ld_reg < 4'd3) ? ld_reg : 4'd0);
    assign p_raddr = (state_reg == S_LD) ? node_reg : cur_reg[NW-1:0];
    assign l_we    = (state_reg == S_OW) && (cur_reg != NO_PARENT)
                     && (32'(cur_reg) < 32'(count)) && (n_reg != count);
    assign l_raddr = inv_reg ? NW'(k_reg - CW'(2)) : NW'(olen_reg - CW'(2));
    assign ld_m1   = ld_reg - 4'd1;

    hrc_ram #(.WIDTH(32), .DEPTH(MD)) u_mat_ram (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(cmd.word_value),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    hrc_ram #(.WIDTH(32), .DEPTH(OD)) u_off_ram (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(cmd.word_value),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    hrc_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_par_ram (
        .clk(clk), .we(p_we), .waddr(cmd.node_index[NW-1:0]), .wdata(cmd.word_value[15:0]),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    hrc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_list_ram (
        .clk(clk), .we(l_we), .waddr(n_reg[NW-1:0]), .wdata(cur_reg[NW-1:0]),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    // multiply-accumulate unit
    assign wsel = ({2'b00, vi_reg} << 1) + {2'b00, vi_reg} + {2'b00, ti_reg};
    assign mctl.mul = (state_reg == S_MUL);
    assign mctl.acc = (state_reg == S_ACC);
    assign mctl.clr = (state_reg == S_RND) || (state_reg == S_INIT);

    hrc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(mctl),
        .a(work_reg[wsel]), .b(mat_reg[mat_index(inv_reg, oi_reg, ti_reg)]),
        .rnd(rnd)
    );

    assign s0 = sat_addsub(work_reg[9],  off_reg[0], state_reg == S_SUB);
    assign s1 = sat_addsub(work_reg[10], off_reg[1], state_reg == S_SUB);
    assign s2 = sat_addsub(work_reg[11], off_reg[2], state_reg == S_SUB);

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        own_next    = own_reg;
        pic_next    = pic_reg;
        last_next   = last_reg;
        root_next   = root_reg;
        n_next      = n_reg;
        olen_next   = olen_reg;
        k_next      = k_reg;
        node_next   = node_reg;
        ld_next     = ld_reg;
        vi_next     = vi_reg;
        oi_next     = oi_reg;
        ti_next     = ti_reg;
        inv_next    = inv_reg;
        ovf_next    = ovf_reg;
        status_next = status_reg;
        elem_next   = elem_reg;
        work_next   = work_reg;
        mat_next    = mat_reg;
        off_next    = off_reg;
        tmp_next    = tmp_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd.action == ACT_QUERY))
                begin
                    pic_next = cmd.node_index;
                    own_next = cmd.owner_index;
                    cur_next = cmd.node_index;
                    n_next   = '0;
                    if (32'(cmd.node_index) >= 32'(count))
                    begin
                        status_next = ST_ENDPOINT;
                        state_next  = S_ERR;
                    end
                    else
                    begin
                        state_next = S_PW;
                    end
                end
            end
            S_PW, S_OW:
            begin
                if (cur_reg == NO_PARENT)
                begin
                    if (state_reg == S_PW)
                    begin
                        root_next = last_reg;
                        cur_next  = own_reg;
                        n_next    = '0;
                        if (32'(own_reg) >= 32'(count))
                        begin
                            status_next = ST_ENDPOINT;
                            state_next  = S_ERR;
                        end
                        else
                        begin
                            state_next = S_OW;
                        end
                    end
                    else
                    begin
                        olen_next = n_reg;
                        if (last_reg != root_reg)
                        begin
                            status_next = ST_ROOTS;
                            state_next  = S_ERR;
                        end
                        else
                        begin
                            state_next = S_INIT;
                        end
                    end
                end
                else if (32'(cur_reg) >= 32'(count))
                begin
                    status_next = ST_PARENT;
                    state_next  = S_ERR;
                end
                else if (n_reg == count)
                begin
                    status_next = ST_CYCLE;
                    state_next  = S_ERR;
                end
                else
                begin
                    last_next  = cur_reg;
                    n_next     = n_reg + CW'(1);
                    state_next = (state_reg == S_PW) ? S_PW_RD : S_OW_RD;
                end
            end
            S_PW_RD, S_OW_RD:
            begin
                cur_next   = p_rdata;
                state_next = (state_reg == S_PW_RD) ? S_PW : S_OW;
            end
            S_INIT:
            begin
                for (int i = 0; i < 9; i++)
                begin
                    work_next[i] = start_unit(i) ? (32'(1) << FRAC_BITS) : 32'd0;
                end
                for (int i = 9; i < 12; i++)
                begin
                    work_next[i] = '0;
                end
                ovf_next   = 1'b0;
                inv_next   = 1'b0;
                node_next  = pic_reg[NW-1:0];
                ld_next    = '0;
                state_next = S_LD;
            end
            S_LD:
            begin
                if (ld_reg != 4'd0)
                begin
                    mat_next[ld_m1] = m_rdata;
                    if (ld_m1 < 4'd3)
                    begin
                        off_next[ld_m1[1:0]] = o_rdata;
                    end
                end
                if ((ld_reg == 4'd1) && !inv_reg)
                begin
                    cur_next = p_rdata;
                end
                vi_next = '0;
                oi_next = '0;
                ti_next = '0;
                if (ld_reg == 4'd9)
                begin
                    state_next = inv_reg ? S_SUB : S_MUL;
                end
                else
                begin
                    ld_next = ld_reg + 4'd1;
                end
            end
            S_SUB, S_ADD:
            begin
                work_next[9]  = s0.value;
                work_next[10] = s1.value;
                work_next[11] = s2.value;
                ovf_next      = ovf_reg | s0.ovf | s1.ovf | s2.ovf;
                state_next    = (state_reg == S_SUB) ? S_MUL : S_NEXT;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (ti_reg == 2'd2)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    ti_next    = ti_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_RND:
            begin
                tmp_next[oi_reg] = rnd.value;
                ovf_next         = ovf_reg | rnd.ovf;
                ti_next          = '0;
                if (oi_reg == 2'd2)
                begin
                    state_next = S_CMT;
                end
                else
                begin
                    oi_next    = oi_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_CMT:
            begin
                for (int o = 0; o < 3; o++)
                begin
                    work_next[4'({2'b00, vi_reg} * 3 + o)] = tmp_reg[o];
                end
                oi_next = '0;
                if (vi_reg == 2'd3)
                begin
                    state_next = inv_reg ? S_NEXT : S_ADD;
                end
                else
                begin
                    vi_next    = vi_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_NEXT:
            begin
                if (!inv_reg)
                begin
                    if (cur_reg == NO_PARENT)
                    begin
                        if (olen_reg <= CW'(1))
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = olen_reg - CW'(1);
                            state_next = S_LST;
                        end
                    end
                    else
                    begin
                        node_next  = cur_reg[NW-1:0];
                        ld_next    = '0;
                        state_next = S_LD;
                    end
                end
                else if (k_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next     = k_reg - CW'(1);
                    state_next = S_LST;
                end
            end
            S_LST:
            begin
                node_next  = l_rdata;
                inv_next   = 1'b1;
                ld_next    = '0;
                state_next = S_LD;
            end
            S_FIN:
            begin
                elem_next = '0;
                if (ovf_reg)
                begin
                    status_next = ST_OVERFLOW;
                    state_next  = S_ERR;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                strobe_next              = 1'b1;
                result_next.element      = elem_reg;
                result_next.result_value = work_reg[0];
                result_next.status       = ST_OK;
                result_next.last         = (elem_reg == ELEM_LAST);
                for (int i = 0; i < 11; i++)
                begin
                    work_next[i] = work_reg[i + 1];
                end
                elem_next = elem_reg + 4'd1;
                if (elem_reg == ELEM_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                strobe_next              = 1'b1;
                result_next.element      = '0;
                result_next.result_value = '0;
                result_next.status       = status_reg;
                result_next.last         = 1'b1;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            strobe         <= 1'b0;
            inv_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe    <= strobe_next;
            inv_reg   <= inv_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        own_reg    <= own_next;
        pic_reg    <= pic_next;
        last_reg   <= last_next;
        root_reg   <= root_next;
        n_reg      <= n_next;
        olen_reg   <= olen_next;
        k_reg      <= k_next;
        node_reg   <= node_next;
        ld_reg     <= ld_next;
        vi_reg     <= vi_next;
        oi_reg     <= oi_next;
        ti_reg     <= ti_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
        work_reg   <= work_next;
        mat_reg    <= mat_next;
        off_reg    <= off_next;
        tmp_reg    <= tmp_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

    // error transactions are single results
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.status != ST_OK) |-> result.last)
        else $error("error result without last");

    // the twelve words of a query leave back to back
    a_emit_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe && (result.element == $past(result.element) + 4'd1))
        else $error("result burst broken");

    // a query ends with its final result
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last)
        else $error("query ended without last result");

    // no result while a new query is being walked
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PW) || (state_reg == S_OW) |-> !strobe)
        else $error("result during chain walk");

endmodule

// File: rtl/core/hrc_ram.sv
// hrc_ram: generic single-port-write, single-port-read ram, registered read
// depends on nothing
module hrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/hrc_mac.sv
// hrc_mac: one multiplier, three-term accumulator, round and saturate
// depends on hrc_pkg
module hrc_mac #(
    parameter int FRAC_BITS = hrc_pkg::FRAC_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hrc_pkg::mac_ctl_t ctl,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output hrc_pkg::sat_t     rnd
);
    import hrc_pkg::*;

    localparam int ACC_W = 66;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= signed'(a) * signed'(b);
        end
    end

    always_comb
    begin
        biased  = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
        shifted = biased >>> FRAC_BITS;
        if (shifted > ACC_W'(32'sh7FFF_FFFF))
        begin
            rnd.value = 32'h7FFF_FFFF;
            rnd.ovf   = 1'b1;
        end
        else if (shifted < -ACC_W'(64'sh8000_0000))
        begin
            rnd.value = 32'h8000_0000;
            rnd.ovf   = 1'b1;
        end
        else
        begin
            rnd.value = shifted[31:0];
            rnd.ovf   = 1'b0;
        end
    end

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for hierarchy_transform_compose
// holds a scoreboard class that predicts each query's transaction results
// depends on hrc_pkg and the hierarchy_transform_compose rtl only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hrc_pkg::*;

    localparam int NODES = 256;
    localparam int FILL = 12;
    localparam int CYCLE_LIMIT = 2000000;

    class transform_scoreboard;
        int node_limit;
        int matrix_words[NODES * 9];
        int offset_words[NODES * 3];
        bit [15:0] parent_of[NODES];
        bit saturated;
        res_t awaited[$];
        int mismatches;
        int results_seen;
        int queries;
        int writes;
        int status_hits[8];

        function new();
            node_limit = 0;
            mismatches = 0;
            results_seen = 0;
            queries = 0;
            writes = 0;
        endfunction

        function int clip(logic signed [67:0] s);
            if (s > 68'sd2147483647)
            begin
                saturated = 1;
                return 32'h7FFF_FFFF;
            end
            if (s < -68'sd2147483648)
            begin
                saturated = 1;
                return 32'h8000_0000;
            end
            return int'(s);
        endfunction

        function int dot3(int a0, int b0, int a1, int b1, int a2, int b2);
            logic signed [67:0] s;
            s = longint'(a0) * longint'(b0);
            s = s + longint'(a1) * longint'(b1);
            s = s + longint'(a2) * longint'(b2);
            s = s + (68'sd1 <<< (FRAC_DEF - 1));
            s = s >>> FRAC_DEF;
            return clip(s);
        endfunction

        function void rotate(input int v[3], input int nd, input bit inv, output int r[3]);
            int m[9];
            for (int i = 0; i < 9; i++)
                m[i] = matrix_words[nd * 9 + i];
            for (int o = 0; o < 3; o++)
            begin
                if (inv)
                    r[o] = dot3(v[0], m[(2 - o) * 3], v[1], m[(2 - o) * 3 + 1],
                                v[2], m[(2 - o) * 3 + 2]);
                else
                    r[o] = dot3(v[0], m[6 + o], v[1], m[3 + o], v[2], m[o]);
            end
        endfunction

        function logic [2:0] walk(int first, int cnt, ref int chain[$]);
            bit seen[NODES];
            int cur;
            chain.delete();
            if (first >= cnt)
                return ST_ENDPOINT;
            cur = first;
            while (cur != int'(NO_PARENT))
            begin
                if (cur >= cnt)
                    return ST_PARENT;
                if (seen[cur])
                    return ST_CYCLE;
                seen[cur] = 1;
                chain.insert(chain.size(), cur);
                cur = parent_of[cur];
            end
            return ST_OK;
        endfunction

        function void push_error(logic [2:0] code);
            res_t r;
            r.element = 0;
            r.result_value = 0;
            r.status = code;
            r.last = 1;
            awaited.insert(awaited.size(), r);
            status_hits[code]++;
        endfunction

        function void note(cmd_t c);
            int pic[$];
            int own[$];
            int cnt;
            int basis[9];
            int pos[3];
            int v[3];
            int r[3];
            int nd;
            logic [2:0] st;
            res_t res;
            if (c.action == ACT_WRITE)
            begin
                writes++;
                if (c.node_index >= NODES)
                    return;
                if (c.word_select < SEL_POS0)
                    matrix_words[c.node_index * 9 + c.word_select] = c.word_value;
                else if (c.word_select < SEL_PARENT)
                    offset_words[c.node_index * 3 + c.word_select - SEL_POS0] = c.word_value;
                else if (c.word_select == SEL_PARENT)
                    parent_of[c.node_index] = c.word_value[15:0];
                return;
            end
            queries++;
            cnt = node_limit < NODES ? node_limit : NODES;
            st = walk(c.node_index, cnt, pic);
            if (st == ST_OK)
                st = walk(c.owner_index, cnt, own);
            if (st == ST_OK && pic[$] != own[$])
                st = ST_ROOTS;
            if (st != ST_OK)
            begin
                push_error(st);
                return;
            end
            saturated = 0;
            for (int i = 0; i < 9; i++)
                basis[i] = start_unit(i) ? (1 << FRAC_DEF) : 0;
            pos = '{0, 0, 0};
            foreach (pic[k])
            begin
                nd = pic[k];
                for (int i = 0; i < 3; i++)
                begin
                    v = '{basis[i * 3], basis[i * 3 + 1], basis[i * 3 + 2]};
                    rotate(v, nd, 0, r);
                    for (int j = 0; j < 3; j++)
                        basis[i * 3 + j] = r[j];
                end
                rotate(pos, nd, 0, r);
                for (int j = 0; j < 3; j++)
                    pos[j] = clip(longint'(r[j]) + longint'(offset_words[nd * 3 + j]));
            end
            for (int k = own.size() - 1; k > 0; k--)
            begin
                nd = own[k - 1];
                for (int j = 0; j < 3; j++)
                    v[j] = clip(longint'(pos[j]) - longint'(offset_words[nd * 3 + j]));
                rotate(v, nd, 1, pos);
                for (int i = 0; i < 3; i++)
                begin
                    v = '{basis[i * 3], basis[i * 3 + 1], basis[i * 3 + 2]};
                    rotate(v, nd, 1, r);
                    for (int j = 0; j < 3; j++)
                        basis[i * 3 + j] = r[j];
                end
            end
            if (saturated)
            begin
                push_error(ST_OVERFLOW);
                return;
            end
            status_hits[ST_OK]++;
            for (int k = 0; k < 12; k++)
            begin
                res.element = 4'(k);
                res.result_value = k < 9 ? basis[k] : pos[k - 9];
                res.status = ST_OK;
                res.last = (res.element == ELEM_LAST);
                awaited.insert(awaited.size(), res);
            end
        endfunction

        function void check(res_t got);
            res_t want;
            results_seen++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.element !== want.element || got.result_value !== want.result_value ||
                got.status !== want.status || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected elem %0d val %h st %0d last %0d, got elem %0d val %h st %0d last %0d",
                             want.element, want.result_value, want.status, want.last,
                             got.element, got.result_value, got.status, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic strobe;
    res_t result;
    int cycles = 0;
    int burst_left;
    transform_scoreboard sb;

    hierarchy_transform_compose DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .strobe(strobe),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && strobe)
            sb.check(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int small_word();
        int w;
        w = $urandom_range(32767, 0) - 16384;
        return w;
    endfunction

    task automatic send(cmd_t c);
        start = 1'b1;
        cmd = c;
        do
            @(posedge clk);
        while (busy);
        sb.note(c);
        @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
            burst_left = $urandom_range(12, 0);
        end
    endtask

    task automatic put(int nd, logic [3:0] sel, int val);
        cmd_t c;
        c.action = ACT_WRITE;
        c.node_index = 16'(nd);
        c.owner_index = 16'($urandom);
        c.word_select = sel;
        c.word_value = val;
        send(c);
    endtask

    task automatic ask(int pic, int own);
        cmd_t c;
        c.action = ACT_QUERY;
        c.node_index = 16'(pic);
        c.owner_index = 16'(own);
        c.word_select = 4'($urandom);
        c.word_value = $urandom;
        send(c);
    endtask

    task automatic set_count(int n);
        start = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = CNT_W'(n);
        @(negedge clk);
        cfg_we = 1'b0;
        sb.node_limit = n;
    endtask

    // cnt never exceeds FILL here, so every in-range node has all its words
    task automatic random_item(int cnt);
        int pick;
        int nd;
        logic [3:0] sel;
        pick = $urandom_range(99, 0);
        if (pick < 50)
        begin
            if ($urandom_range(9, 0) == 0)
                ask($urandom_range(65535, 0), $urandom_range(65535, 0));
            else
                ask($urandom_range(cnt + 1, 0), $urandom_range(cnt + 1, 0));
        end
        else
        begin
            nd = $urandom_range(9, 0) == 0 ? $urandom_range(65535, 0) : $urandom_range(FILL + 3, 0);
            sel = 4'($urandom_range(15, 0));
            if (sel == SEL_PARENT)
            begin
                pick = $urandom_range(9, 0);
                if (pick < 7 && nd > 1 && nd < NODES)
                    put(nd, sel, {16'($urandom_range(65535, 0)), 16'($urandom_range(nd - 1, 0))});
                else if (pick < 9)
                    put(nd, sel, {16'($urandom), NO_PARENT});
                else
                    put(nd, sel, $urandom);
            end
            else if ($urandom_range(3, 0) == 0)
                put(nd, sel, $urandom);
            else
                put(nd, sel, sel < SEL_POS0 ? small_word() * 6 : small_word() * 64);
        end
        pace();
    endtask

    initial
    begin
        int counts[5];
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every node that a query can reach gets all its words first
        for (int n = 0; n < FILL; n++)
        begin
            for (int s = 0; s < 9; s++)
                put(n, 4'(s), (s == 2 || s == 4 || s == 6 ? 65536 : 0) + small_word() / 2);
            for (int s = 9; s < 12; s++)
                put(n, 4'(s), small_word() * 64);
            put(n, SEL_PARENT, n < 2 ? int'(NO_PARENT) : $urandom_range(n / 2, n / 4));
        end

        ask(0, 0);
        set_count(NODES);
        ask(0, 0);
        ask(9, 0);
        ask(0, 1);
        ask(65535, 0);
        ask(0, 65535);
        put(250, SEL_PARENT, 251);
        put(251, SEL_PARENT, 250);
        put(252, SEL_PARENT, 256);
        ask(250, 0);
        ask(0, 251);
        ask(252, 0);
        ask(0, 252);
        put(65535, 4'd15, 32'h8000_0000);
        put(4, 4'd13, 32'h7FFF_FFFF);
        put(3, 4'd0, 32'h7FFF_FFFF);
        put(3, 4'd6, 32'h8000_0000);
        ask(3, 1);
        ask(7, 3);
        ask(10, 11);

        set_count(511);
        ask(5, 3);
        ask(300, 0);

        counts = '{FILL, 7, 2, $urandom_range(FILL, 0), FILL};
        foreach (counts[p])
        begin
            set_count(counts[p]);
            for (int i = 0; i < 35; i++)
                random_item(counts[p]);
        end
        set_count(0);
        ask(0, 0);

        start = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("covered %0d queries and %0d node writes, %0d result transactions",
                 sb.queries, sb.writes, sb.results_seen);
        $display("status mix ok/endpoint/parent/cycle/roots/overflow: %0d %0d %0d %0d %0d %0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4], sb.status_hits[5]);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
